// ----- hdl/vector_to_polar_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the vector-to-polar core
// Short forms for clocked concurrent checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TO_POLAR_CORE_ASSERT_SVH
`define VECTOR_TO_POLAR_CORE_ASSERT_SVH

// same-cycle implication
`define V2P_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define V2P_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/v2p_pkg.sv -----
// ----------------------------------------------------------------------------
// v2p_pkg
// Widths, stage payload types and CORDIC helpers for the vector-to-polar core.
// ----------------------------------------------------------------------------
package v2p_pkg;

	localparam int COORD_W      = 16;
	localparam int ANGLE_W      = 16;
	localparam int SQ_W         = 2 * COORD_W;
	localparam int ACC_W        = 64;
	localparam int CORDIC_STEPS = 60;
	localparam int ROOT_STEPS   = COORD_W;
	localparam int NORM_MSB     = 60;
	localparam logic [COORD_W-1:0] LIMIT_RESET = 16'd1;
	localparam logic [ACC_W-1:0] TURN_PER_RAD = 64'd2935890503282001226;

	typedef struct packed {
		logic [COORD_W:0] ax;
		logic [COORD_W:0] ay;
		logic [SQ_W-1:0]  ax2;
		logic [SQ_W-1:0]  ay2;
		logic             xneg;
		logic             yneg;
	} front_t;

	typedef struct packed {
		logic [SQ_W-1:0]         sq;
		logic [SQ_W-1:0]         rem;
		logic [SQ_W-1:0]         root;
		logic signed [ACC_W-1:0] cx;
		logic signed [ACC_W-1:0] cy;
		logic signed [ACC_W-1:0] z;
		logic                    swap;
		logic                    xneg;
		logic                    yneg;
		logic                    nz;
	} pipe_t;

	// shift-subtract quotient, elaboration only
	function automatic logic [ACC_W-1:0] udiv_c(input logic [ACC_W-1:0] num,
			input logic [ACC_W-1:0] den);
		logic [ACC_W:0]   r;
		logic [ACC_W-1:0] q;
		r = '0;
		q = '0;
		for (int b = ACC_W - 1; b >= 0; b--) begin
			r = {r[ACC_W-1:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in turns, Q64
	function automatic logic [ACC_W-1:0] atan_turn(input int i);
		logic [ACC_W-1:0]   rad;
		logic [ACC_W-1:0]   term;
		logic [2*ACC_W-1:0] prod;
		int                 sh;
		rad = '0;
		if (i == 0)
			return 64'd1 << 61;
		for (int k = 0; k < 62; k++) begin
			sh = i * (2 * k + 1);
			if (sh > 61)
				break;
			term = udiv_c((64'd1 << 61) >> sh, 64'(2 * k + 1));
			if (k % 2 == 1)
				rad = rad - term;
			else
				rad = rad + term;
		end
		prod = {64'd0, rad} * {64'd0, TURN_PER_RAD};
		return prod[ACC_W+60:61];
	endfunction

	// one CORDIC rotation plus, in the early stages, one root digit
	function automatic pipe_t stage_step(input pipe_t p, input int i,
			input logic [ACC_W-1:0] atan_i);
		pipe_t                   n;
		logic signed [ACC_W-1:0] dx;
		logic signed [ACC_W-1:0] dy;
		logic [SQ_W-1:0]         bitv;
		logic [SQ_W-1:0]         trial;
		n  = p;
		dx = p.cy >>> i;
		dy = p.cx >>> i;
		if (!p.cy[ACC_W-1]) begin
			n.cx = p.cx + dx;
			n.cy = p.cy - dy;
			n.z  = p.z + signed'(atan_i);
		end else begin
			n.cx = p.cx - dx;
			n.cy = p.cy + dy;
			n.z  = p.z - signed'(atan_i);
		end
		if (i < ROOT_STEPS) begin
			bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * i);
			trial = p.root + bitv;
			if (p.rem >= trial) begin
				n.rem  = p.rem - trial;
				n.root = (p.root >> 1) + bitv;
			end else begin
				n.root = p.root >> 1;
			end
		end
		return n;
	endfunction

endpackage

// ----- hdl/vector_to_polar_core.sv -----
// ----------------------------------------------------------------------------
// vector_to_polar_core
// Squared magnitude, floor square root and full-turn angle of a Q1.15 vector.
// ----------------------------------------------------------------------------
// Takes one vector per cycle; each result, once its vector is accepted, passes
// through one stage for absolute values and squares, one for the sum and
// normalization, 60 CORDIC vectoring stages (the first 16 also resolve one
// root digit each) and one stage that unfolds and rounds the angle. A stalled
// output holds the whole pipeline. The limit register should be written only
// while the pipeline is empty.
module vector_to_polar_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [v2p_pkg::COORD_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [v2p_pkg::COORD_W-1:0] vec_x,
	input  logic signed [v2p_pkg::COORD_W-1:0] vec_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [v2p_pkg::SQ_W-1:0]      squared_magnitude,
	output logic [v2p_pkg::COORD_W-1:0]   magnitude,
	output logic [v2p_pkg::ANGLE_W-1:0]   angle
);

	localparam int CW = v2p_pkg::COORD_W;
	localparam int AW = v2p_pkg::ACC_W;
	localparam int NS = v2p_pkg::CORDIC_STEPS;

	logic                      pipe_en;
	logic [CW-1:0]             limit_q;
	logic                      vld_s1;
	v2p_pkg::front_t           fr_s1;
	v2p_pkg::front_t           fr_c;
	logic                      vld_s2;
	v2p_pkg::pipe_t            pay_s2;
	v2p_pkg::pipe_t            pay_c;
	logic                      vld_sk [NS];
	v2p_pkg::pipe_t            pay_sk [NS];
	logic                      out_valid_q;
	logic [v2p_pkg::SQ_W-1:0]  out_sq_q;
	logic [CW-1:0]             out_mag_q;
	logic [v2p_pkg::ANGLE_W-1:0] out_ang_q;
	logic [v2p_pkg::ANGLE_W-1:0] ang_c;
	logic [CW:0]               hi_c;
	logic [CW:0]               lo_c;
	logic [5:0]                msb_c;
	logic [5:0]                sh_c;
	logic [2*CW+1:0]           ax2_c;
	logic [2*CW+1:0]           ay2_c;
	logic [AW-1:0]             f_c;

	assign pipe_en   = !out_valid_q || out_ready;
	assign in_ready  = pipe_en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= v2p_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// absolute values and squares
	always_comb begin
		fr_c.xneg = vec_x[CW-1];
		fr_c.yneg = vec_y[CW-1];
		fr_c.ax   = vec_x[CW-1] ? ((CW+1)'(0) - {vec_x[CW-1], vec_x}) : {1'b0, vec_x};
		fr_c.ay   = vec_y[CW-1] ? ((CW+1)'(0) - {vec_y[CW-1], vec_y}) : {1'b0, vec_y};
		ax2_c     = fr_c.ax * fr_c.ax;
		ay2_c     = fr_c.ay * fr_c.ay;
		fr_c.ax2  = ax2_c[v2p_pkg::SQ_W-1:0];
		fr_c.ay2  = ay2_c[v2p_pkg::SQ_W-1:0];
	end

	// sum, fold to first octant, normalize
	always_comb begin
		pay_c.sq   = fr_s1.ax2 + fr_s1.ay2;
		pay_c.rem  = pay_c.sq;
		pay_c.root = '0;
		pay_c.z    = '0;
		pay_c.xneg = fr_s1.xneg;
		pay_c.yneg = fr_s1.yneg;
		pay_c.swap = fr_s1.ay > fr_s1.ax;
		hi_c       = pay_c.swap ? fr_s1.ay : fr_s1.ax;
		lo_c       = pay_c.swap ? fr_s1.ax : fr_s1.ay;
		pay_c.nz   = hi_c != '0;
		msb_c      = '0;
		for (int b = 0; b <= CW; b++) begin
			if (hi_c[b])
				msb_c = 6'(b);
		end
		sh_c     = 6'(v2p_pkg::NORM_MSB) - msb_c;
		pay_c.cx = signed'(AW'(hi_c) << sh_c);
		pay_c.cy = signed'(AW'(lo_c) << sh_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fr_s1  <= fr_c;
			pay_s2 <= pay_c;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		localparam logic [AW-1:0] ATAN_I = v2p_pkg::atan_turn(i);
		logic           vld_in;
		v2p_pkg::pipe_t pay_in;
		if (i == 0) begin : g_first
			assign vld_in = vld_s2;
			assign pay_in = pay_s2;
		end else begin : g_next
			assign vld_in = vld_sk[i-1];
			assign pay_in = pay_sk[i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[i] <= 1'b0;
			end else if (pipe_en) begin
				vld_sk[i] <= vld_in;
			end
		end
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				pay_sk[i] <= v2p_pkg::stage_step(pay_in, i, ATAN_I);
			end
		end
	end

	// unfold octant angle into a turn and round
	always_comb begin
		f_c = pay_sk[NS-1].z[AW-1] ? '0 : AW'(pay_sk[NS-1].z);
		if (pay_sk[NS-1].swap)
			f_c = (AW'(1) << (AW - 2)) - f_c;
		if (pay_sk[NS-1].xneg)
			f_c = (AW'(1) << (AW - 1)) - f_c;
		if (pay_sk[NS-1].yneg)
			f_c = AW'(0) - f_c;
		f_c = f_c + (AW'(1) << (AW - 1 - v2p_pkg::ANGLE_W));
		if (pay_sk[NS-1].nz && (pay_sk[NS-1].root[CW-1:0] >= limit_q))
			ang_c = f_c[AW-1 -: v2p_pkg::ANGLE_W];
		else
			ang_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			out_valid_q <= vld_sk[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			out_sq_q  <= pay_sk[NS-1].sq;
			out_mag_q <= pay_sk[NS-1].root[CW-1:0];
			out_ang_q <= ang_c;
		end
	end

	assign out_valid         = out_valid_q;
	assign squared_magnitude = out_sq_q;
	assign magnitude         = out_mag_q;
	assign angle             = out_ang_q;

endmodule

// ----- hdl/v2p_checker.sv -----
// ----------------------------------------------------------------------------
// v2p_checker
// Port-level checks for the vector-to-polar core, bound to its top level.
// ----------------------------------------------------------------------------
`include "vector_to_polar_core_assert.svh"

module v2p_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [v2p_pkg::COORD_W-1:0]   cfg_data,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [v2p_pkg::COORD_W-1:0]   vec_x,
	input logic [v2p_pkg::COORD_W-1:0]   vec_y,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [v2p_pkg::SQ_W-1:0]      squared_magnitude,
	input logic [v2p_pkg::COORD_W-1:0]   magnitude,
	input logic [v2p_pkg::ANGLE_W-1:0]   angle
);

	`V2P_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(squared_magnitude) && $stable(magnitude) && $stable(angle), "output word changed while stalled")
	`V2P_ASSERT_NOW(a_in_ready, out_ready || !out_valid, in_ready, "input blocked with free output")
	`V2P_ASSERT_NOW(a_root_low, out_valid, 34'(magnitude) * 34'(magnitude) <= 34'(squared_magnitude), "magnitude too large")
	`V2P_ASSERT_NOW(a_root_high, out_valid, (34'(magnitude) + 34'd1) * (34'(magnitude) + 34'd1) > 34'(squared_magnitude), "magnitude too small")
	`V2P_ASSERT_NOW(a_zero_vec, out_valid && squared_magnitude == '0, angle == '0 && magnitude == '0, "zero vector gave nonzero word")

endmodule

bind vector_to_polar_core v2p_checker u_v2p_checker (.*);
